// ----- sv/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the periodic timer scheduler
// Holds field widths, action and result codes, and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int ID_W        = 4;   // bits to name one timer
  localparam int CNT_W       = 5;   // bits to hold a list fill, 0..TIMER_COUNT

  localparam logic [7:0] MIN_WAIT_RESET = 8'd5;

  // input actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_STOP   = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;   // acknowledged, no effect

  // result kinds
  localparam logic [1:0] KIND_EXPIRED  = 2'd0;
  localparam logic [1:0] KIND_WAIT     = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_ACK      = 2'd3;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_START      = 4'd1;
  localparam op_t OP_STOP       = 4'd2;
  localparam op_t OP_ACK        = 4'd3;
  localparam op_t OP_FILE_LOAD  = 4'd4;
  localparam op_t OP_FILE_CLEAR = 4'd5;
  localparam op_t OP_INS_LAST   = 4'd6;
  localparam op_t OP_INS_SCAN   = 4'd7;
  localparam op_t OP_SET_LAST   = 4'd8;
  localparam op_t OP_FIRE       = 4'd9;
  localparam op_t OP_SWAP       = 4'd10;
  localparam op_t OP_WAIT_PREP  = 4'd11;
  localparam op_t OP_WAIT_EMIT  = 4'd12;

  // table read address select
  typedef logic [1:0] rsel_t;
  localparam rsel_t RS_PEND    = 2'd0;
  localparam rsel_t RS_LIST    = 2'd1;
  localparam rsel_t RS_AFRONT  = 2'd2;
  localparam rsel_t RS_CLOSEST = 2'd3;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
    logic  latch;     // capture the input word
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       file_done;
    logic       hit_last;
    logic       hit_scan;
    logic       backwards;
    logic       due;
    logic       a_empty;
  } status_t;

endpackage

// ----- sv/pts_req_if.sv -----
// ----------------------------------------------------------------------------
// pts_req_if: request channel
// Carries one command word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  timer_id;
  logic [15:0] period_ms;
  logic [31:0] now_ms;
  logic [31:0] after_ms;

  modport source (output valid, action, timer_id, period_ms, now_ms, after_ms,
                  input ready);
  modport sink (input valid, action, timer_id, period_ms, now_ms, after_ms,
                output ready);
endinterface

// ----- sv/pts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pts_rsp_if: result channel
// Carries one result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  fired_id;
  logic [31:0] elapsed_ms;
  logic [31:0] wait_ms;
  logic        last;

  modport source (output valid, kind, fired_id, elapsed_ms, wait_ms, last,
                  input ready);
  modport sink (input valid, kind, fired_id, elapsed_ms, wait_ms, last,
                output ready);
endinterface

// ----- sv/pts_datapath.sv -----
// ----------------------------------------------------------------------------
// pts_datapath: timer tables, sorted lists and result register
// Executes one operation per cycle as the controller commands.
// ----------------------------------------------------------------------------
module pts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pts_pkg::cmd_t       cmd,
  output pts_pkg::status_t    stat,
  input  logic [1:0]          action,
  input  logic [3:0]          timer_id,
  input  logic [15:0]         period_ms,
  input  logic [31:0]         now_ms,
  input  logic [31:0]         after_ms,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output logic [1:0]          kind,
  output logic [3:0]          fired_id,
  output logic [31:0]         elapsed_ms,
  output logic [31:0]         wait_ms,
  output logic                last
);

  localparam int N  = pts_pkg::TIMER_COUNT;
  localparam int IW = pts_pkg::ID_W;
  localparam int CW = pts_pkg::CNT_W;

  logic [1:0]    act_r;
  logic [IW-1:0] id_r;
  logic [15:0]   per_r;
  logic [31:0]   now_r;
  logic [31:0]   after_r;

  logic [15:0]   period  [N];
  logic [31:0]   start_t [N];
  logic [31:0]   endt    [N];
  logic [N-1:0]  running;

  logic [IW-1:0] plist [N];
  logic [IW-1:0] alist [N];
  logic [IW-1:0] ilist [N];
  logic [CW-1:0] pcnt, acnt, icnt;

  logic [31:0]   last_upd;
  logic [7:0]    min_wait;
  logic [CW-1:0] fi;
  logic [IW-1:0] scan_i;
  logic [IW-1:0] cand;
  logic [31:0]   key;
  logic          tgt;      // 1 files into the wrapped list
  logic [31:0]   raw, corr;
  logic          any;

  logic [IW-1:0] rd_id, lidx, lid, ins_pos;
  logic [CW-1:0] tcnt, tcnt_m1;
  logic [31:0]   end_rd, st_rd;
  logic [15:0]   per_rd;
  logic          hit_last, hit_scan, do_ins;
  logic [IW-1:0] ins_list [N];
  logic [IW-1:0] rm_a [N];
  logic [IW-1:0] rm_i [N];
  logic [IW-1:0] rm_p [N];
  logic [N-1:0]  ma, mi, mp;
  logic          found_a, found_i, found_p;
  logic [31:0]   wdiff, wsel;

  // table reads through one address
  always_comb begin
    tcnt    = tgt ? icnt : acnt;
    tcnt_m1 = tcnt - CW'(1);
    lidx    = (cmd.op == pts_pkg::OP_INS_LAST) ? tcnt_m1[IW-1:0] : scan_i;
    lid     = tgt ? ilist[lidx] : alist[lidx];
    case (cmd.rsel)
      pts_pkg::RS_PEND:    rd_id = plist[fi[IW-1:0]];
      pts_pkg::RS_LIST:    rd_id = lid;
      pts_pkg::RS_AFRONT:  rd_id = alist[0];
      pts_pkg::RS_CLOSEST: rd_id = (acnt != '0) ? alist[0] : ilist[0];
      default:             rd_id = id_r;
    endcase
    end_rd = endt[rd_id];
    st_rd  = start_t[rd_id];
    per_rd = period[rd_id];
  end

  assign hit_last = (tcnt == '0) || (end_rd <= key);
  assign hit_scan = (end_rd >= key);
  assign do_ins   = ((cmd.op == pts_pkg::OP_INS_LAST) && hit_last) ||
                    ((cmd.op == pts_pkg::OP_INS_SCAN) && hit_scan);
  assign ins_pos  = (cmd.op == pts_pkg::OP_INS_LAST) ? tcnt[IW-1:0] : scan_i;

  // sorted insertion: open a slot at ins_pos
  always_comb begin
    for (int j = 0; j < N; j++) begin
      if (j[IW-1:0] == ins_pos) begin
        ins_list[j] = cand;
      end else if (j[IW-1:0] > ins_pos) begin
        ins_list[j] = tgt ? ilist[(j > 0) ? j - 1 : 0] : alist[(j > 0) ? j - 1 : 0];
      end else begin
        ins_list[j] = tgt ? ilist[j] : alist[j];
      end
    end
  end

  // removal by id: ids are unique, close the gap past the match
  always_comb begin
    logic sa, si, sp;
    sa = 1'b0;
    si = 1'b0;
    sp = 1'b0;
    for (int j = 0; j < N; j++) begin
      ma[j] = (alist[j] == id_r) && (CW'(j) < acnt);
      mi[j] = (ilist[j] == id_r) && (CW'(j) < icnt);
      mp[j] = (plist[j] == id_r) && (CW'(j) < pcnt);
      sa = sa | ma[j];
      si = si | mi[j];
      sp = sp | mp[j];
      rm_a[j] = (sa && j < N - 1) ? alist[(j < N - 1) ? j + 1 : j] : alist[j];
      rm_i[j] = (si && j < N - 1) ? ilist[(j < N - 1) ? j + 1 : j] : ilist[j];
      rm_p[j] = (sp && j < N - 1) ? plist[(j < N - 1) ? j + 1 : j] : plist[j];
    end
    found_a = sa;
    found_i = si;
    found_p = sp;
  end

  always_comb begin
    wdiff = raw - corr;
    if (!any) begin
      wsel = '1;
    end else if (corr >= raw) begin
      wsel = '0;
    end else if ((wdiff != '0) && (wdiff < {24'd0, min_wait})) begin
      wsel = {24'd0, min_wait};
    end else begin
      wsel = wdiff;
    end
  end

  always_comb begin
    stat.action    = act_r;
    stat.file_done = (fi == pcnt);
    stat.hit_last  = hit_last;
    stat.hit_scan  = hit_scan;
    stat.backwards = (now_r < last_upd);
    stat.due       = (acnt != '0) && (end_rd <= now_r);
    stat.a_empty   = (acnt == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= action;
      id_r    <= timer_id;
      per_r   <= period_ms;
      now_r   <= now_ms;
      after_r <= after_ms;
    end
    if (cfg_we) begin
      min_wait <= cfg_data;
    end
    case (cmd.op)
      pts_pkg::OP_START: begin
        fired_id   <= id_r;
        elapsed_ms <= '0;
        wait_ms    <= '0;
        last       <= 1'b1;
        if (running[id_r]) begin
          kind <= pts_pkg::KIND_REJECTED;
        end else begin
          kind           <= pts_pkg::KIND_ACK;
          period[id_r]   <= per_r;
          start_t[id_r]  <= now_r;
          endt[id_r]     <= now_r + {16'd0, per_r};
          running[id_r]  <= 1'b1;
          for (int j = 1; j < N; j++) begin
            plist[j] <= plist[j-1];
          end
          plist[0] <= id_r;
          pcnt     <= pcnt + CW'(1);
        end
      end
      pts_pkg::OP_STOP: begin
        kind          <= pts_pkg::KIND_ACK;
        fired_id      <= id_r;
        elapsed_ms    <= '0;
        wait_ms       <= '0;
        last          <= 1'b1;
        running[id_r] <= 1'b0;
        if (found_a) begin
          alist <= rm_a;
          acnt  <= acnt - CW'(1);
        end else if (found_i) begin
          ilist <= rm_i;
          icnt  <= icnt - CW'(1);
        end else if (found_p) begin
          plist <= rm_p;
          pcnt  <= pcnt - CW'(1);
        end
      end
      pts_pkg::OP_ACK: begin
        kind       <= pts_pkg::KIND_ACK;
        fired_id   <= id_r;
        elapsed_ms <= '0;
        wait_ms    <= '0;
        last       <= 1'b1;
      end
      pts_pkg::OP_FILE_LOAD: begin
        cand <= rd_id;
        key  <= end_rd;
        tgt  <= (end_rd < last_upd);
        fi   <= fi + CW'(1);
      end
      pts_pkg::OP_FILE_CLEAR: begin
        pcnt <= '0;
        fi   <= '0;
      end
      pts_pkg::OP_INS_LAST, pts_pkg::OP_INS_SCAN: begin
        if (do_ins) begin
          if (tgt) begin
            ilist <= ins_list;
            icnt  <= icnt + CW'(1);
          end else begin
            alist <= ins_list;
            acnt  <= acnt + CW'(1);
          end
        end
        scan_i <= (cmd.op == pts_pkg::OP_INS_LAST) ? '0 : scan_i + IW'(1);
      end
      pts_pkg::OP_SET_LAST: begin
        last_upd <= now_r;
      end
      pts_pkg::OP_FIRE: begin
        kind           <= pts_pkg::KIND_EXPIRED;
        fired_id       <= rd_id;
        elapsed_ms     <= last_upd - st_rd;
        wait_ms        <= '0;
        last           <= 1'b0;
        start_t[rd_id] <= last_upd;
        endt[rd_id]    <= last_upd + {16'd0, per_rd};
        for (int j = 0; j < N - 1; j++) begin
          alist[j] <= alist[j+1];
        end
        acnt               <= acnt - CW'(1);
        plist[pcnt[IW-1:0]] <= rd_id;
        pcnt               <= pcnt + CW'(1);
      end
      pts_pkg::OP_SWAP: begin
        alist <= ilist;
        ilist <= alist;
        acnt  <= icnt;
        icnt  <= acnt;
      end
      pts_pkg::OP_WAIT_PREP: begin
        any  <= (acnt != '0) || (icnt != '0);
        raw  <= end_rd - now_r;
        corr <= after_r - now_r;
      end
      pts_pkg::OP_WAIT_EMIT: begin
        kind       <= pts_pkg::KIND_WAIT;
        fired_id   <= '0;
        elapsed_ms <= '0;
        wait_ms    <= wsel;
        last       <= 1'b1;
      end
      default: begin
      end
    endcase
    if (rst) begin
      running  <= '0;
      pcnt     <= '0;
      acnt     <= '0;
      icnt     <= '0;
      last_upd <= '0;
      min_wait <= pts_pkg::MIN_WAIT_RESET;
      fi       <= '0;
      scan_i   <= '0;
    end
  end

endmodule

// ----- sv/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl: command sequencer
// Walks each request through its steps and owns the result valid flag.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  pts_pkg::status_t stat,
  output pts_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_FILE      = 4'd2;
  localparam logic [3:0] S_INS_LAST  = 4'd3;
  localparam logic [3:0] S_INS_SCAN  = 4'd4;
  localparam logic [3:0] S_BACK      = 4'd5;
  localparam logic [3:0] S_FIRE_ALL  = 4'd6;
  localparam logic [3:0] S_DUE       = 4'd7;
  localparam logic [3:0] S_WAIT_PREP = 4'd8;
  localparam logic [3:0] S_WAIT_EMIT = 4'd9;

  logic [3:0] state, state_next;
  logic       pass, pass_next;
  logic       slot_free, load;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd.op     = pts_pkg::OP_NOP;
    cmd.rsel   = pts_pkg::RS_AFRONT;
    cmd.latch  = req_valid && req_ready;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.action == pts_pkg::ACT_UPDATE) begin
          pass_next  = 1'b0;
          state_next = S_FILE;
        end else if (slot_free) begin
          load = 1'b1;
          case (stat.action)
            pts_pkg::ACT_START: cmd.op = pts_pkg::OP_START;
            pts_pkg::ACT_STOP:  cmd.op = pts_pkg::OP_STOP;
            default:            cmd.op = pts_pkg::OP_ACK;
          endcase
          state_next = S_IDLE;
        end
      end
      S_FILE: begin
        cmd.rsel = pts_pkg::RS_PEND;
        if (stat.file_done) begin
          cmd.op     = pts_pkg::OP_FILE_CLEAR;
          state_next = pass ? S_WAIT_PREP : S_BACK;
        end else begin
          cmd.op     = pts_pkg::OP_FILE_LOAD;
          state_next = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        cmd.rsel   = pts_pkg::RS_LIST;
        cmd.op     = pts_pkg::OP_INS_LAST;
        state_next = stat.hit_last ? S_FILE : S_INS_SCAN;
      end
      S_INS_SCAN: begin
        cmd.rsel = pts_pkg::RS_LIST;
        cmd.op   = pts_pkg::OP_INS_SCAN;
        if (stat.hit_scan) state_next = S_FILE;
      end
      S_BACK: begin
        cmd.op     = pts_pkg::OP_SET_LAST;
        state_next = stat.backwards ? S_FIRE_ALL : S_DUE;
      end
      S_FIRE_ALL: begin
        if (stat.a_empty) begin
          cmd.op     = pts_pkg::OP_SWAP;
          state_next = S_DUE;
        end else if (slot_free) begin
          cmd.op = pts_pkg::OP_FIRE;
          load   = 1'b1;
        end
      end
      S_DUE: begin
        if (!stat.due) begin
          pass_next  = 1'b1;
          state_next = S_FILE;
        end else if (slot_free) begin
          cmd.op = pts_pkg::OP_FIRE;
          load   = 1'b1;
        end
      end
      S_WAIT_PREP: begin
        cmd.rsel   = pts_pkg::RS_CLOSEST;
        cmd.op     = pts_pkg::OP_WAIT_PREP;
        state_next = S_WAIT_EMIT;
      end
      S_WAIT_EMIT: begin
        if (slot_free) begin
          cmd.op     = pts_pkg::OP_WAIT_EMIT;
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/periodic_timer_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_scheduler: sorted periodic timer queue with tick wraparound
// Start, stop and update requests for sixteen timers; updates report each
// expiry and then the wait until the next one.
// ----------------------------------------------------------------------------
// Order: start, stop and other words load their one result in the dispatch
//   state after acceptance. An update files pending timers, flushes and swaps
//   the lists when time went backwards, fires due timers, one expiry per cycle
//   while the result register has room, files again and loads its wait word.
// Throughput: one request at a time; the next word is taken the cycle after
//   the last result is loaded. A full result register adds its stall cycles.
// Reset: synchronous; clears all lists, running flags and the last update
//   time, and sets the minimum wait to 5.
module periodic_timer_scheduler (
  input  logic       clk,
  input  logic       rst,
  pts_req_if.sink    req,
  pts_rsp_if.source  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  pts_pkg::cmd_t    cmd;
  pts_pkg::status_t stat;

  // the minimum wait register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: one step per cycle, stalls on a full result register
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, lists and the result word
  pts_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (req.action),
    .timer_id   (req.timer_id),
    .period_ms  (req.period_ms),
    .now_ms     (req.now_ms),
    .after_ms   (req.after_ms),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .kind       (rsp.kind),
    .fired_id   (rsp.fired_id),
    .elapsed_ms (rsp.elapsed_ms),
    .wait_ms    (rsp.wait_ms),
    .last       (rsp.last)
  );

  // an accepted word takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  // a wait word always closes an update
  a_wait_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == pts_pkg::KIND_WAIT) |-> rsp.last)
    else $error("wait word not marked last");

  // an expiry is never the closing word
  a_expiry_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == pts_pkg::KIND_EXPIRED) |-> !rsp.last)
    else $error("expiry marked last");

endmodule

// ----- verif/pts_tb_if.sv -----
// ----------------------------------------------------------------------------
// pts_tb_if: testbench-side channel notes
// The request and result interfaces come from the design sources; this file
// holds the small helper types that the testbench modules share.
// ----------------------------------------------------------------------------
package pts_tb_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_id;
    logic [31:0] elapsed_ms;
    logic [31:0] wait_ms;
    logic        last;
  } result_word_t;

endpackage

// ----- verif/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker: scoreboard for the periodic timer scheduler
// Mirrors the timer lists, predicts the result words of each accepted
// request and compares them in order with the words the block delivers.
// ----------------------------------------------------------------------------
module pts_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  logic [1:0] req_action,
  input  logic [3:0] req_timer_id,
  input  logic [15:0] req_period_ms,
  input  logic [31:0] req_now_ms,
  input  logic [31:0] req_after_ms,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  pts_tb_pkg::result_word_t rsp_word,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending_words
);

  logic [15:0] tm_period [pts_pkg::TIMER_COUNT];
  logic [31:0] tm_start [pts_pkg::TIMER_COUNT];
  logic        tm_running [pts_pkg::TIMER_COUNT];
  logic [3:0]  new_list [$];
  logic [3:0]  run_list [$];
  logic [3:0]  wrap_list [$];
  logic [31:0] last_tick;
  logic [7:0]  min_wait;
  pts_tb_pkg::result_word_t expected_words [$];

  function automatic logic [31:0] end_time(logic [3:0] id);
    return tm_start[id] + {16'd0, tm_period[id]};
  endfunction

  // Insert by end time; append when the back entry is not later.
  task automatic insert_sorted(ref logic [3:0] q[$], input logic [3:0] id);
    int pos;
    pos = q.size();
    if (q.size() != 0 && end_time(q[q.size()-1]) > end_time(id)) begin
      for (int i = 0; i < q.size(); i++) begin
        if (end_time(q[i]) >= end_time(id)) begin
          pos = i;
          break;
        end
      end
    end
    q.insert(pos, id);
  endtask

  function automatic bit drop_id(ref logic [3:0] q[$], input logic [3:0] id);
    for (int i = 0; i < q.size(); i++) begin
      if (q[i] == id) begin
        q.delete(i);
        return 1;
      end
    end
    return 0;
  endfunction

  task automatic file_new_timers();
    foreach (new_list[i]) begin
      if (end_time(new_list[i]) < last_tick) insert_sorted(wrap_list, new_list[i]);
      else insert_sorted(run_list, new_list[i]);
    end
    new_list.delete();
  endtask

  task automatic push_word(logic [1:0] k, logic [3:0] id, logic [31:0] el,
                           logic [31:0] w, logic l);
    pts_tb_pkg::result_word_t r;
    r.kind = k; r.fired_id = id; r.elapsed_ms = el; r.wait_ms = w; r.last = l;
    expected_words.insert(expected_words.size(), r);
  endtask

  task automatic fire_front();
    logic [3:0] id;
    id = run_list[0];
    run_list.delete(0);
    push_word(pts_pkg::KIND_EXPIRED, id, last_tick - tm_start[id], 32'd0, 1'b0);
    tm_start[id] = last_tick;
    new_list.insert(new_list.size(), id);
  endtask

  task automatic schedule_request(logic [1:0] act, logic [3:0] id, logic [15:0] per,
                                  logic [31:0] now, logic [31:0] aft);
    logic [3:0] tmp [$];
    logic [31:0] closest, raw, corr, w;
    bit any, gone;
    case (act)
      pts_pkg::ACT_START: begin
        if (tm_running[id] || new_list.size() >= pts_pkg::TIMER_COUNT) begin
          push_word(pts_pkg::KIND_REJECTED, id, 32'd0, 32'd0, 1'b1);
        end else begin
          tm_period[id] = per;
          tm_start[id] = now;
          tm_running[id] = 1'b1;
          new_list.insert(0, id);
          push_word(pts_pkg::KIND_ACK, id, 32'd0, 32'd0, 1'b1);
        end
      end
      pts_pkg::ACT_STOP: begin
        gone = drop_id(run_list, id);
        if (!gone) gone = drop_id(wrap_list, id);
        if (!gone) gone = drop_id(new_list, id);
        tm_running[id] = 1'b0;
        push_word(pts_pkg::KIND_ACK, id, 32'd0, 32'd0, 1'b1);
      end
      pts_pkg::ACT_UPDATE: begin
        file_new_timers();
        if (now < last_tick) begin
          // time went backwards: flush the active queue, then swap
          last_tick = now;
          while (run_list.size() != 0) fire_front();
          tmp = run_list;
          run_list = wrap_list;
          wrap_list = tmp;
        end else begin
          last_tick = now;
        end
        while (run_list.size() != 0 && end_time(run_list[0]) <= now) fire_front();
        file_new_timers();
        any = 1;
        closest = 32'd0;
        if (run_list.size() != 0) closest = end_time(run_list[0]);
        else if (wrap_list.size() != 0) closest = end_time(wrap_list[0]);
        else any = 0;
        if (!any) begin
          w = '1;
        end else begin
          raw = closest - now;
          corr = aft - now;
          if (corr >= raw) begin
            w = 32'd0;
          end else begin
            w = raw - corr;
            if (w != 0 && w < {24'd0, min_wait}) w = {24'd0, min_wait};
          end
        end
        push_word(pts_pkg::KIND_WAIT, 4'd0, 32'd0, w, 1'b1);
      end
      default: begin
        push_word(pts_pkg::KIND_ACK, id, 32'd0, 32'd0, 1'b1);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pts_tb_pkg::result_word_t want;
    if (rst) begin
      for (int i = 0; i < pts_pkg::TIMER_COUNT; i++) begin
        tm_start[i] = '0;
        tm_running[i] = 1'b0;
        tm_period[i] = '0;
      end
      new_list.delete();
      run_list.delete();
      wrap_list.delete();
      expected_words.delete();
      last_tick = '0;
      min_wait = pts_pkg::MIN_WAIT_RESET;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) min_wait = cfg_data;
      if (req_valid && req_ready)
        schedule_request(req_action, req_timer_id, req_period_ms, req_now_ms,
                         req_after_ms);
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word kind", 32'(rsp_word.kind), 32'd0);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (rsp_word.kind !== want.kind)
            report_mismatch("kind", 32'(rsp_word.kind), 32'(want.kind));
          if (rsp_word.fired_id !== want.fired_id)
            report_mismatch("fired_id", 32'(rsp_word.fired_id), 32'(want.fired_id));
          if (rsp_word.elapsed_ms !== want.elapsed_ms)
            report_mismatch("elapsed_ms", rsp_word.elapsed_ms, want.elapsed_ms);
          if (rsp_word.wait_ms !== want.wait_ms)
            report_mismatch("wait_ms", rsp_word.wait_ms, want.wait_ms);
          if (rsp_word.last !== want.last)
            report_mismatch("last", 32'(rsp_word.last), 32'(want.last));
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the periodic timer scheduler
// Drives directed and random start, stop, update and unused words with random
// idling on both channels, steps min_wait_ms through several settings, and
// leaves all checking to pts_checker.
// ----------------------------------------------------------------------------
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  int fail_count;
  int pending_words;
  int cycle_count = 0;
  bit idle_enable = 1'b1;
  logic [31:0] clock_ms = '0;   // running tick count fed to updates
  pts_tb_pkg::result_word_t rsp_word;

  pts_req_if req ();
  pts_rsp_if rsp ();

  periodic_timer_scheduler dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  assign rsp_word = '{kind: rsp.kind, fired_id: rsp.fired_id,
                      elapsed_ms: rsp.elapsed_ms, wait_ms: rsp.wait_ms, last: rsp.last};

  pts_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req_action(req.action),
    .req_timer_id(req.timer_id), .req_period_ms(req.period_ms),
    .req_now_ms(req.now_ms), .req_after_ms(req.after_ms),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: worst case is ~180 words, each with up to 17 results, two full
  // filing passes and result-side stalls; this limit is several times that.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts, none in the closing stretch.
  initial begin
    int hold;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 8);
        rsp.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Send one word and hold it until accepted; idle bursts go before it.
  // Valid stays up after acceptance until the next word or drain drops it.
  task automatic send_word(logic [1:0] act, logic [3:0] id, logic [15:0] per,
                           logic [31:0] now, logic [31:0] aft);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.timer_id <= id;
    req.period_ms <= per;
    req.now_ms <= now;
    req.after_ms <= aft;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_min_wait(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Advance the running clock and issue an update with a small correction.
  task automatic tick_update(logic [31:0] step, logic [31:0] corr);
    clock_ms = clock_ms + step;
    send_word(pts_pkg::ACT_UPDATE, 4'($urandom), 16'($urandom), clock_ms,
              clock_ms + corr);
  endtask

  task automatic random_phase(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_word(pts_pkg::ACT_START, 4'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 300)), clock_ms, $urandom);
      else if (pick < 50)
        send_word(pts_pkg::ACT_STOP, 4'($urandom), 16'($urandom), $urandom, $urandom);
      else if (pick < 88)
        tick_update($urandom_range(0, 200), $urandom_range(0, 20));
      else if (pick < 92)
        send_word(pts_pkg::ACT_UNUSED, 4'($urandom), 16'($urandom), $urandom, $urandom);
      else if (pick < 96) begin
        // jump backwards in time: flush and swap the queues
        clock_ms = clock_ms - $urandom_range(1, 100000);
        tick_update(32'd0, $urandom_range(0, 300));
      end else
        send_word(pts_pkg::ACT_UPDATE, 4'($urandom), 16'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = pts_pkg::ACT_START;
    req.timer_id = '0;
    req.period_ms = '0;
    req.now_ms = '0;
    req.after_ms = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every action, rejects, wrap, backwards time.
    send_word(pts_pkg::ACT_UPDATE, 4'd0, 16'd0, 32'd0, 32'd0);           // nothing armed
    send_word(pts_pkg::ACT_START, 4'd0, 16'hFFFF, 32'd0, '1);
    send_word(pts_pkg::ACT_START, 4'd15, 16'd0, 32'd10, 32'd0);
    send_word(pts_pkg::ACT_START, 4'd0, 16'd1, 32'd0, 32'd0);            // already running
    send_word(pts_pkg::ACT_START, 4'd5, 16'd20, 32'd0, 32'd0);
    send_word(pts_pkg::ACT_START, 4'd6, 16'd20, 32'd0, 32'd0);           // tie in end time
    send_word(pts_pkg::ACT_START, 4'd7, 16'd100, 32'hFFFF_FFF0, 32'd0);  // wraps past zero
    send_word(pts_pkg::ACT_UNUSED, 4'd9, 16'h1234, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(pts_pkg::ACT_UPDATE, 4'd0, 16'd0, 32'd10, 32'd11);
    send_word(pts_pkg::ACT_UPDATE, 4'd0, 16'd0, 32'd25, 32'd25);
    send_word(pts_pkg::ACT_UPDATE, 4'd0, 16'd0, 32'd40, 32'h0000_FFFF);  // correction swamps
    send_word(pts_pkg::ACT_STOP, 4'd6, 16'd0, 32'd0, 32'd0);
    send_word(pts_pkg::ACT_STOP, 4'd6, 16'd0, 32'd0, 32'd0);             // stop an idle timer
    send_word(pts_pkg::ACT_UPDATE, 4'd0, 16'd0, '1, '1);
    send_word(pts_pkg::ACT_UPDATE, 4'd0, 16'd0, 32'd30, 32'd31);         // backwards
    send_word(pts_pkg::ACT_STOP, 4'd15, 16'd0, 32'd0, 32'd0);
    send_word(pts_pkg::ACT_STOP, 4'd0, 16'd0, 32'd0, 32'd0);
    clock_ms = 32'd30;
    drain();

    write_min_wait(8'd0);
    random_phase(40);
    drain();   // sender holds until every result has come
    write_min_wait(8'd255);
    random_phase(40);
    drain();
    write_min_wait(8'($urandom_range(1, 254)));
    random_phase(40);
    drain();
    write_min_wait(8'd5);
    idle_enable = 1'b0;
    random_phase(40);

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pts_pkg.sv
sv/pts_req_if.sv
sv/pts_rsp_if.sv
sv/pts_datapath.sv
sv/pts_ctrl.sv
sv/periodic_timer_scheduler.sv
verif/pts_tb_if.sv
verif/pts_checker.sv
verif/testbench.sv
